// ----- rtl/core/rdsm_pkg.sv -----
`default_nettype none

package rdsm_pkg;

	localparam int MAX_TOKENS = 32;
	localparam int NPOS       = MAX_TOKENS + 1;
	localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
	localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
	localparam int LVLS       = $clog2(NPOS);

	localparam logic [7:0] STAR_BYTE = 8'h2A;
	localparam logic [7:0] DOT_BYTE  = 8'h2E;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef enum logic [1:0] {
		OP_PATTERN = 2'd0,
		OP_TEXT    = 2'd1,
		OP_END     = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic matched;
		logic pattern_overflow;
	} out_item_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data_byte;
		logic       is_star;
	} cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/rdsm_front.sv -----
`default_nettype none

module rdsm_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire rdsm_pkg::in_item_t item,
	output logic                  cmd_valid,
	output rdsm_pkg::cmd_t        cmd,
	input  wire logic             cmd_take
);

	rdsm_pkg::cmd_t                     entry_q [rdsm_pkg::QDEPTH];
	logic [rdsm_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [rdsm_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [rdsm_pkg::QCNT_W-1:0]        cnt_q;
	rdsm_pkg::cmd_t                     classified;
	logic                               do_push;
	logic                               do_pop;

	// decode the action and flag a star byte once, ahead of the engine
	always_comb begin
		classified.op        = rdsm_pkg::op_t'(item.action);
		classified.data_byte = item.data_byte;
		classified.is_star   = (item.data_byte == rdsm_pkg::STAR_BYTE);
	end

	assign full      = (cnt_q == rdsm_pkg::QCNT_W'(rdsm_pkg::QDEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = entry_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = cmd_take & cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rdsm_engine.sv -----
`default_nettype none

module rdsm_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	input  wire rdsm_pkg::cmd_t     cmd,
	output logic                    cmd_take,
	output logic                    res_push,
	output rdsm_pkg::out_item_t     res,
	input  wire logic               res_full
);

	logic [7:0]                          tok_byte_q [rdsm_pkg::MAX_TOKENS];
	logic [rdsm_pkg::MAX_TOKENS-1:0]     tok_star_q;
	logic [rdsm_pkg::CNT_W-1:0]          count_q;
	logic [rdsm_pkg::NPOS-1:0]           active_q;
	logic                                ovf_q;

	logic [rdsm_pkg::MAX_TOKENS-1:0]     live;
	logic [rdsm_pkg::MAX_TOKENS-1:0]     star_eff;
	logic [rdsm_pkg::MAX_TOKENS-1:0]     hit;
	logic [rdsm_pkg::MAX_TOKENS-1:0]     sel;
	logic [rdsm_pkg::NPOS-1:0]           cur;
	logic [rdsm_pkg::NPOS-1:0]           nxt;
	logic [rdsm_pkg::IDX_W-1:0]          last_idx;
	logic [rdsm_pkg::IDX_W-1:0]          new_idx;
	logic                                star_last;
	logic                                at_cap;

	// prefix scan: a set position leaks forward across each run of starred tokens
	function automatic logic [rdsm_pkg::NPOS-1:0] close_set(
		input logic [rdsm_pkg::NPOS-1:0]       s,
		input logic [rdsm_pkg::MAX_TOKENS-1:0] st
	);
		logic [rdsm_pkg::NPOS-1:0] g;
		logic [rdsm_pkg::NPOS-1:0] p;
		g = s;
		p = {st, 1'b0};
		for (int l = 0; l < rdsm_pkg::LVLS; l++) begin
			g = g | (p & (g << (1 << l)));
			p = p & (p << (1 << l));
		end
		return g;
	endfunction

	always_comb begin
		for (int i = 0; i < rdsm_pkg::MAX_TOKENS; i++) begin
			live[i] = (rdsm_pkg::CNT_W'(i) < count_q);
			hit[i]  = live[i] & ((tok_byte_q[i] == rdsm_pkg::DOT_BYTE) |
				(tok_byte_q[i] == cmd.data_byte));
		end
	end

	assign star_eff = tok_star_q & live;
	assign cur      = close_set(active_q, star_eff);
	assign sel      = cur[rdsm_pkg::MAX_TOKENS-1:0] & hit;
	assign nxt      = {1'b0, sel & star_eff} | {sel & ~star_eff, 1'b0};

	assign last_idx  = rdsm_pkg::IDX_W'(count_q - 1'b1);
	assign new_idx   = count_q[rdsm_pkg::IDX_W-1:0];
	assign at_cap    = (count_q >= rdsm_pkg::CNT_W'(rdsm_pkg::MAX_TOKENS));
	assign star_last = cmd.is_star && (count_q != '0) && !tok_star_q[last_idx];

	assign cmd_take = cmd_valid & ~res_full;
	assign res_push = cmd_take & (cmd.op == rdsm_pkg::OP_END);

	always_comb begin
		res.matched          = cur[count_q] & ~ovf_q;
		res.pattern_overflow = ovf_q;
	end

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.op == rdsm_pkg::OP_PATTERN && !ovf_q) begin
			priority if (star_last) begin
				tok_star_q[last_idx] <= 1'b1;
			end else if (!at_cap) begin
				tok_byte_q[new_idx] <= cmd.data_byte;
				tok_star_q[new_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			ovf_q    <= 1'b0;
			active_q <= rdsm_pkg::NPOS'(1);
		end else if (cmd_take) begin
			unique case (cmd.op)
				rdsm_pkg::OP_PATTERN: begin
					if (!ovf_q && !star_last) begin
						if (at_cap) begin
							ovf_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				rdsm_pkg::OP_TEXT: begin
					active_q <= nxt;
				end
				rdsm_pkg::OP_END: begin
					active_q <= rdsm_pkg::NPOS'(1);
				end
				rdsm_pkg::OP_CLEAR: begin
					count_q  <= '0;
					ovf_q    <= 1'b0;
					active_q <= rdsm_pkg::NPOS'(1);
				end
				default: begin
					active_q <= active_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/rdsm_result_q.sv -----
`default_nettype none

module rdsm_result_q (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire rdsm_pkg::out_item_t wr_data,
	output logic                     q_full,
	output logic                     empty,
	input  wire logic                pop,
	output rdsm_pkg::out_item_t      result
);

	rdsm_pkg::out_item_t                 entry_q [rdsm_pkg::QDEPTH];
	logic [rdsm_pkg::QPTR_W-1:0]         wr_ptr_q;
	logic [rdsm_pkg::QPTR_W-1:0]         rd_ptr_q;
	logic [rdsm_pkg::QCNT_W-1:0]         cnt_q;
	logic                                do_wr;
	logic                                do_rd;

	assign q_full = (cnt_q == rdsm_pkg::QCNT_W'(rdsm_pkg::QDEPTH));
	assign empty  = (cnt_q == '0);
	assign result = entry_q[rd_ptr_q];
	assign do_wr  = wr_en & ~q_full;
	assign do_rd  = pop & ~empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			priority if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/regex_dot_star_matcher_top.sv -----
// Whole-string matcher for patterns of literal bytes, '.' and 'x*'.
// Input queue: push an item while full is low. action 0 appends a pattern
// byte, 1 feeds a text byte, 2 ends the text, 3 clears the pattern.
// Output queue: while empty is low the oldest result (matched,
// pattern_overflow) is on result; pop takes it. Only an end-of-text item
// produces a result; the pattern is kept for the next text.
// Throughput: one item per cycle while the result queue is not full. Each
// text byte runs the whole NFA update, including the star closure (a
// six-level prefix scan over 33 positions), ahead of the active register.
// Path: an end-of-text item is written into the 2-entry input queue; the
// engine evaluates it combinationally at the head of that queue and writes
// its result into the 2-entry result queue, where it waits to be popped.
// When pop stays low the result queue fills, the engine holds, the input
// queue fills and full rises; nothing is dropped.
// Reset (arst_n low) empties both queues, clears the token count and the
// overflow flag and arms only the start position. The token store itself
// is not cleared; entries beyond the count are never used.
`default_nettype none

module regex_dot_star_matcher_top (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire rdsm_pkg::in_item_t  item,
	output logic                     empty,
	input  wire logic                pop,
	output rdsm_pkg::out_item_t      result
);

	rdsm_pkg::cmd_t      cmd;
	rdsm_pkg::out_item_t res;
	logic                cmd_valid;
	logic                cmd_take;
	logic                res_push;
	logic                res_full;

	rdsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take)
	);

	rdsm_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_take  (cmd_take),
		.res_push  (res_push),
		.res       (res),
		.res_full  (res_full)
	);

	rdsm_result_q u_result_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res),
		.q_full  (res_full),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

`default_nettype wire

// ----- rtl/core/rdsm_checker.sv -----
`default_nettype none

module rdsm_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                push,
	input wire logic                full,
	input wire logic                empty,
	input wire logic                pop,
	input wire rdsm_pkg::out_item_t result
);

	// both queues come out of reset drained
	a_reset_state: assert property (@(posedge clk)
		!arst_n |=> (!full && empty))
		else $error("queues not drained during reset");

	// overflow must force a mismatch
	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(result.matched && result.pattern_overflow))
		else $error("match reported with pattern overflow");

	// input queue only fills after a transfer in
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");

	// a stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result)))
		else $error("waiting result changed or vanished");

endmodule

bind regex_dot_star_matcher_top rdsm_checker u_rdsm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

`default_nettype wire
